[hw/rtl/fic_pkg.sv]
package fic_pkg;

  // Default payload limit in bytes.
  localparam int unsigned MaxPayloadDef = 4096;

  // Reflected CRC-32C constants.
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'h82F6_3B78;

  // Status codes.
  localparam logic [2:0] StPrimary  = 3'd0;
  localparam logic [2:0] StFallback = 3'd1;
  localparam logic [2:0] StOverflow = 3'd2;
  localparam logic [2:0] StParse    = 3'd3;
  localparam logic [2:0] StTimeRej  = 3'd4;

  // Record outcome codes.
  localparam logic [1:0] OcAccepted = 2'd0;
  localparam logic [1:0] OcParse    = 2'd1;
  localparam logic [1:0] OcTimeRej  = 2'd2;
  localparam logic [1:0] OcRingFull = 2'd3;

  // Event counter slots.
  localparam int unsigned NumCounters  = 6;
  localparam int unsigned CntTsSubst   = 0;
  localparam int unsigned CntParse     = 1;
  localparam int unsigned CntTimeRej   = 2;
  localparam int unsigned CntPrimary   = 3;
  localparam int unsigned CntFallback  = 4;
  localparam int unsigned CntOverflow  = 5;

  // Counter increments produced by one frame decision.
  typedef struct packed {
    logic [1:0] ts_subst;
    logic       parse;
    logic       time_rej;
    logic       primary;
    logic       fallback;
    logic       overflow;
  } cnt_bump_t;

  // One byte step of the reflected CRC-32C, eight bit steps unrolled.
  function automatic logic [31:0] crc32c_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h00_0000, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'h0000_0000);
    end
    return c;
  endfunction

endpackage

[hw/rtl/fic_if.sv]
// Input channel: one payload word per handshake.
interface fic_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         feed_class;
  logic [7:0]         data_byte;
  logic               has_byte;
  logic               last;
  logic signed [63:0] event_time;
  logic signed [63:0] source_time;
  logic signed [63:0] now_time;
  logic               primary_full;
  logic               fallback_full;

  modport source (
    output valid, feed_class, data_byte, has_byte, last, event_time, source_time,
           now_time, primary_full, fallback_full,
    input  ready
  );
  modport sink (
    input  valid, feed_class, data_byte, has_byte, last, event_time, source_time,
           now_time, primary_full, fallback_full,
    output ready
  );
endinterface

// Result channel: one record word per frame.
interface fic_out_if #(
  parameter int unsigned SizeW = 13
);
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [1:0]         outcome;
  logic [7:0]         out_feed_class;
  logic signed [63:0] eff_event_time;
  logic signed [63:0] eff_source_time;
  logic signed [63:0] ingest_time;
  logic [SizeW-1:0]   payload_size;
  logic [31:0]        payload_crc;
  logic [1:0]         fallback_uses;

  modport source (
    output valid, status, outcome, out_feed_class, eff_event_time, eff_source_time,
           ingest_time, payload_size, payload_crc, fallback_uses,
    input  ready
  );
  modport sink (
    input  valid, status, outcome, out_feed_class, eff_event_time, eff_source_time,
           ingest_time, payload_size, payload_crc, fallback_uses,
    output ready
  );
endinterface

[hw/rtl/fic_frame_acc.sv]
// Running CRC and saturating byte count of the frame in progress.
module fic_frame_acc #(
  parameter int unsigned MaxPayload = fic_pkg::MaxPayloadDef,
  parameter int unsigned CountW     = $clog2(MaxPayload + 2)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              has_byte_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_i,
  output logic [31:0]       crc_o,
  output logic [CountW-1:0] count_o
);

  logic [31:0]       crc_q, crc_d;
  logic [CountW-1:0] count_q, count_d;

  // CRC and count including the word being processed.
  always_comb begin
    crc_o   = crc_q;
    count_o = count_q;
    if (has_byte_i && (count_q < CountW'(MaxPayload))) begin
      crc_o = fic_pkg::crc32c_byte(crc_q, data_byte_i);
    end
    if (has_byte_i && (count_q <= CountW'(MaxPayload))) begin
      count_o = count_q + CountW'(1);
    end
  end

  // Rearm at the end of each frame.
  always_comb begin
    crc_d   = crc_q;
    count_d = count_q;
    if (step_i) begin
      if (last_i) begin
        crc_d   = fic_pkg::CrcInit;
        count_d = '0;
      end else begin
        crc_d   = crc_o;
        count_d = count_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= fic_pkg::CrcInit;
      count_q <= '0;
    end else begin
      crc_q   <= crc_d;
      count_q <= count_d;
    end
  end

endmodule

[hw/rtl/fic_verdict.sv]
// Timestamp substitution, frame checks and ring placement for one frame.
module fic_verdict #(
  parameter int unsigned MaxPayload = fic_pkg::MaxPayloadDef,
  parameter int unsigned CountW     = $clog2(MaxPayload + 2),
  parameter int unsigned SizeW      = $clog2(MaxPayload + 1)
) (
  input  logic signed [63:0]  event_time_i,
  input  logic signed [63:0]  source_time_i,
  input  logic signed [63:0]  now_time_i,
  input  logic                primary_full_i,
  input  logic                fallback_full_i,
  input  logic                truncate_i,
  input  logic [CountW-1:0]   count_i,
  input  logic [31:0]         crc_i,
  output logic [2:0]          status_o,
  output logic [1:0]          outcome_o,
  output logic signed [63:0]  eff_event_time_o,
  output logic signed [63:0]  eff_source_time_o,
  output logic [SizeW-1:0]    size_o,
  output logic [31:0]         crc_o,
  output logic [1:0]          uses_o,
  output fic_pkg::cnt_bump_t  bump_o
);

  logic src_ok, ev_ok, order_ok, oversize;

  // A time that is zero or negative is missing and takes its fallback.
  assign src_ok            = source_time_i > 64'sd0;
  assign eff_source_time_o = src_ok ? source_time_i : now_time_i;
  assign ev_ok             = event_time_i > 64'sd0;
  assign eff_event_time_o  = ev_ok ? event_time_i : eff_source_time_o;
  assign uses_o            = 2'(!src_ok) + 2'(!ev_ok);

  assign order_ok = (eff_event_time_o > 64'sd0) &&
                    (eff_source_time_o >= eff_event_time_o) &&
                    (now_time_i >= eff_source_time_o);
  assign oversize = count_i > CountW'(MaxPayload);

  // Checks in priority order: empty, time order, size, then ring room.
  always_comb begin
    status_o        = fic_pkg::StParse;
    outcome_o       = fic_pkg::OcParse;
    size_o          = '0;
    crc_o           = '0;
    bump_o          = '0;
    bump_o.ts_subst = uses_o;
    if (count_i == '0) begin
      bump_o.parse = 1'b1;
    end else if (!order_ok) begin
      status_o        = fic_pkg::StTimeRej;
      outcome_o       = fic_pkg::OcTimeRej;
      bump_o.time_rej = 1'b1;
    end else if (oversize && !truncate_i) begin
      bump_o.parse = 1'b1;
    end else if (!primary_full_i) begin
      status_o       = fic_pkg::StPrimary;
      outcome_o      = fic_pkg::OcAccepted;
      size_o         = oversize ? SizeW'(MaxPayload) : SizeW'(count_i);
      crc_o          = ~crc_i;
      bump_o.primary = 1'b1;
    end else begin
      outcome_o       = fic_pkg::OcRingFull;
      bump_o.fallback = 1'b1;
      if (fallback_full_i) begin
        status_o        = fic_pkg::StOverflow;
        bump_o.overflow = 1'b1;
      end else begin
        status_o = fic_pkg::StFallback;
      end
    end
  end

endmodule

[hw/rtl/fic_event_cnt.sv]
// Wrapping event counters, bumped once per finished frame.
module fic_event_cnt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               bump_en_i,
  input  fic_pkg::cnt_bump_t bump_i
);

  logic [31:0] cnt_q [fic_pkg::NumCounters];
  logic [31:0] cnt_d [fic_pkg::NumCounters];

  always_comb begin
    for (int i = 0; i < int'(fic_pkg::NumCounters); i++) begin
      cnt_d[i] = cnt_q[i];
    end
    if (bump_en_i) begin
      cnt_d[fic_pkg::CntTsSubst]  = cnt_q[fic_pkg::CntTsSubst] + 32'(bump_i.ts_subst);
      cnt_d[fic_pkg::CntParse]    = cnt_q[fic_pkg::CntParse] + 32'(bump_i.parse);
      cnt_d[fic_pkg::CntTimeRej]  = cnt_q[fic_pkg::CntTimeRej] + 32'(bump_i.time_rej);
      cnt_d[fic_pkg::CntPrimary]  = cnt_q[fic_pkg::CntPrimary] + 32'(bump_i.primary);
      cnt_d[fic_pkg::CntFallback] = cnt_q[fic_pkg::CntFallback] + 32'(bump_i.fallback);
      cnt_d[fic_pkg::CntOverflow] = cnt_q[fic_pkg::CntOverflow] + 32'(bump_i.overflow);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(fic_pkg::NumCounters); i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < int'(fic_pkg::NumCounters); i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

endmodule

[hw/rtl/frame_ingest_checker.sv]
// Frame ingest checker. Each input word carries at most one payload byte, and the
// word marked last carries the header times and ring flags. The block takes one
// word per clock cycle while its input is not stalled; each word passes
// through an input register, where a single unrolled CRC-32C byte step and the
// byte count update; from there the last word of a frame loads a result register.
// The one-byte CRC step in that stage sets the rate. The input side stalls only
// when a finished record still waits in the result register and the next last
// word needs it. Setting the truncate bit clips frames longer than MaxPayload
// bytes instead of dropping them; write it only while no frame is in flight.
module frame_ingest_checker #(
  parameter int unsigned MaxPayload = fic_pkg::MaxPayloadDef,
  localparam int unsigned CountW    = $clog2(MaxPayload + 2),
  localparam int unsigned SizeW     = $clog2(MaxPayload + 1)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  fic_in_if.sink    in_i,
  fic_out_if.source out_o
);

  // Configuration register.
  logic trunc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trunc_q <= 1'b0;
    end else if (cfg_we_i) begin
      trunc_q <= cfg_wdata_i;
    end
  end

  // Input register stage.
  logic               s1_valid_q;
  logic [7:0]         s1_kind_q;
  logic [7:0]         s1_byte_q;
  logic               s1_has_q;
  logic               s1_last_q;
  logic signed [63:0] s1_ev_q;
  logic signed [63:0] s1_src_q;
  logic signed [63:0] s1_now_q;
  logic               s1_pfull_q;
  logic               s1_ffull_q;
  logic               s1_adv;
  logic               in_acc;
  logic               out_load;

  logic out_valid_q;

  assign s1_adv      = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_load    = s1_adv && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q  <= in_i.feed_class;
      s1_byte_q  <= in_i.data_byte;
      s1_has_q   <= in_i.has_byte;
      s1_last_q  <= in_i.last;
      s1_ev_q    <= in_i.event_time;
      s1_src_q   <= in_i.source_time;
      s1_now_q   <= in_i.now_time;
      s1_pfull_q <= in_i.primary_full;
      s1_ffull_q <= in_i.fallback_full;
    end
  end

  // Frame accumulator.
  logic [31:0]       acc_crc;
  logic [CountW-1:0] acc_count;

  fic_frame_acc #(
    .MaxPayload(MaxPayload),
    .CountW    (CountW)
  ) u_frame_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_adv),
    .has_byte_i (s1_has_q),
    .data_byte_i(s1_byte_q),
    .last_i     (s1_last_q),
    .crc_o      (acc_crc),
    .count_o    (acc_count)
  );

  // Frame decision.
  logic [2:0]         vd_status;
  logic [1:0]         vd_outcome;
  logic signed [63:0] vd_ev;
  logic signed [63:0] vd_src;
  logic [SizeW-1:0]   vd_size;
  logic [31:0]        vd_crc;
  logic [1:0]         vd_uses;
  fic_pkg::cnt_bump_t vd_bump;

  fic_verdict #(
    .MaxPayload(MaxPayload),
    .CountW    (CountW),
    .SizeW     (SizeW)
  ) u_verdict (
    .event_time_i     (s1_ev_q),
    .source_time_i    (s1_src_q),
    .now_time_i       (s1_now_q),
    .primary_full_i   (s1_pfull_q),
    .fallback_full_i  (s1_ffull_q),
    .truncate_i       (trunc_q),
    .count_i          (acc_count),
    .crc_i            (acc_crc),
    .status_o         (vd_status),
    .outcome_o        (vd_outcome),
    .eff_event_time_o (vd_ev),
    .eff_source_time_o(vd_src),
    .size_o           (vd_size),
    .crc_o            (vd_crc),
    .uses_o           (vd_uses),
    .bump_o           (vd_bump)
  );

  fic_event_cnt u_event_cnt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bump_en_i(out_load),
    .bump_i   (vd_bump)
  );

  // Result register.
  logic               out_valid_d;
  logic [2:0]         status_q;
  logic [1:0]         outcome_q;
  logic [7:0]         kind_q;
  logic signed [63:0] ev_q;
  logic signed [63:0] src_q;
  logic signed [63:0] now_q;
  logic [SizeW-1:0]   size_q;
  logic [31:0]        crc_q;
  logic [1:0]         uses_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q  <= vd_status;
      outcome_q <= vd_outcome;
      kind_q    <= s1_kind_q;
      ev_q      <= vd_ev;
      src_q     <= vd_src;
      now_q     <= s1_now_q;
      size_q    <= vd_size;
      crc_q     <= vd_crc;
      uses_q    <= vd_uses;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = status_q;
  assign out_o.outcome         = outcome_q;
  assign out_o.out_feed_class  = kind_q;
  assign out_o.eff_event_time  = ev_q;
  assign out_o.eff_source_time = src_q;
  assign out_o.ingest_time     = now_q;
  assign out_o.payload_size    = size_q;
  assign out_o.payload_crc     = crc_q;
  assign out_o.fallback_uses   = uses_q;

endmodule

[hw/rtl/fic_checker.sv]
// Port-level checks on the frame ingest checker.
module fic_checker #(
  parameter int unsigned SizeW = 13
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             in_last_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [2:0]       status_i,
  input logic [1:0]       outcome_i,
  input logic [SizeW-1:0] payload_size_i,
  input logic [31:0]      payload_crc_i,
  input logic [1:0]       fallback_uses_i
);

  // A waiting record holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(status_i) && $stable(outcome_i) &&
      $stable(payload_size_i) && $stable(payload_crc_i))
    else $error("result word changed while stalled");

  // A record appearing on an idle output stems from an accepted last word.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2))
    else $error("result word without a preceding last word");

  // Only primary accepts carry size and CRC.
  a_primary_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != fic_pkg::StPrimary) |->
      (payload_size_i == '0) && (payload_crc_i == '0))
    else $error("size or CRC on a record not accepted to primary");

  // Status and outcome agree, and at most two fallbacks apply.
  a_status_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      ((outcome_i == fic_pkg::OcRingFull) ==
       ((status_i == fic_pkg::StFallback) || (status_i == fic_pkg::StOverflow))) &&
      ((outcome_i == fic_pkg::OcAccepted) == (status_i == fic_pkg::StPrimary)) &&
      (fallback_uses_i != 2'd3))
    else $error("inconsistent status, outcome or fallback count");

endmodule

bind frame_ingest_checker fic_checker #(
  .SizeW(SizeW)
) u_fic_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_last_i      (in_i.last),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .outcome_i      (out_o.outcome),
  .payload_size_i (out_o.payload_size),
  .payload_crc_i  (out_o.payload_crc),
  .fallback_uses_i(out_o.fallback_uses)
);

[tb/sv/testbench.sv]
module testbench;

  localparam int unsigned MaxBytes = fic_pkg::MaxPayloadDef;
  localparam logic signed [63:0] MaxTime = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MinTime = 64'sh8000_0000_0000_0000;

  // One input word as the sender presents it.
  typedef struct {
    logic [7:0]         kind;
    logic [7:0]         data;
    logic               has;
    logic               last;
    logic signed [63:0] ev;
    logic signed [63:0] src;
    logic signed [63:0] now;
    logic               pfull;
    logic               ffull;
  } frame_word_t;

  // One finished ingest record.
  typedef struct {
    logic [2:0]         status;
    logic [1:0]         outcome;
    logic [7:0]         kind;
    logic signed [63:0] ev;
    logic signed [63:0] src;
    logic signed [63:0] now;
    logic [12:0]        size;
    logic [31:0]        crc;
    logic [1:0]         uses;
  } ingest_record_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  fic_in_if word_if ();
  fic_out_if #(.SizeW(13)) record_if ();

  frame_ingest_checker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (word_if),
    .out_o      (record_if)
  );

  // Words waiting to be sent and records the block still owes.
  frame_word_t    word_backlog[$];
  ingest_record_t due_records[$];

  // Mirror of the block's frame state and setting.
  logic [31:0] crc_state = fic_pkg::CrcInit;
  int unsigned byte_tally = 0;
  logic [31:0] frame_events[fic_pkg::NumCounters] = '{default: 32'd0};
  logic        trunc_mode = 1'b0;

  frame_word_t    word_on_bus;
  ingest_record_t head_record;
  int unsigned    send_gap = 0;
  int unsigned    recv_gap = 0;
  int unsigned    hold_left = 0;
  bit             send_calm = 1'b0;
  bit             recv_calm = 1'b0;
  int unsigned    records_seen = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    words_queued = 0;
  int unsigned    blank_pct = 0;

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("mismatch in %s on record %0d: got %h, expected %h",
             what, records_seen, got, want);
  endtask

  // Fold one accepted word into the frame state; a last word yields a record.
  task automatic absorb_word(input frame_word_t w);
    ingest_record_t     r;
    logic signed [63:0] src;
    logic signed [63:0] ev;
    logic [31:0]        c;
    if (w.has) begin
      if (byte_tally < MaxBytes) begin
        c = crc_state ^ {24'h00_0000, w.data};
        for (int k = 0; k < 8; k++) begin
          c = (c >> 1) ^ (c[0] ? fic_pkg::CrcPoly : 32'h0000_0000);
        end
        crc_state = c;
      end
      if (byte_tally <= MaxBytes) byte_tally++;
    end
    if (!w.last) return;

    // Missing times fall back to the clock, then to the source time.
    r.uses = 2'd0;
    src = w.src;
    ev = w.ev;
    if (src <= 0) begin
      src = w.now;
      r.uses = r.uses + 2'd1;
    end
    if (ev <= 0) begin
      ev = src;
      r.uses = r.uses + 2'd1;
    end
    frame_events[fic_pkg::CntTsSubst] += 32'(r.uses);

    // Checks run in order: empty payload, time order, size, then ring space.
    r.size = '0;
    r.crc = '0;
    if (byte_tally == 0) begin
      r.status = fic_pkg::StParse;
      r.outcome = fic_pkg::OcParse;
      frame_events[fic_pkg::CntParse]++;
    end else if (!(ev > 0 && src >= ev && w.now >= src)) begin
      r.status = fic_pkg::StTimeRej;
      r.outcome = fic_pkg::OcTimeRej;
      frame_events[fic_pkg::CntTimeRej]++;
    end else if (byte_tally > MaxBytes && !trunc_mode) begin
      r.status = fic_pkg::StParse;
      r.outcome = fic_pkg::OcParse;
      frame_events[fic_pkg::CntParse]++;
    end else if (!w.pfull) begin
      r.status = fic_pkg::StPrimary;
      r.outcome = fic_pkg::OcAccepted;
      r.size = 13'((byte_tally > MaxBytes) ? MaxBytes : byte_tally);
      r.crc = ~crc_state;
      frame_events[fic_pkg::CntPrimary]++;
    end else begin
      r.outcome = fic_pkg::OcRingFull;
      frame_events[fic_pkg::CntFallback]++;
      if (w.ffull) begin
        r.status = fic_pkg::StOverflow;
        frame_events[fic_pkg::CntOverflow]++;
      end else begin
        r.status = fic_pkg::StFallback;
      end
    end
    r.kind = w.kind;
    r.ev = ev;
    r.src = src;
    r.now = w.now;
    due_records.push_back(r);
    crc_state = fic_pkg::CrcInit;
    byte_tally = 0;
  endtask

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 70) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: present queued words with random gaps and track every accepted word.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      word_if.valid <= 1'b0;
    end else begin
      if (word_if.valid && word_if.ready) begin
        absorb_word(word_on_bus);
      end
      if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
      if (!word_if.valid || word_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          word_if.valid <= 1'b0;
        end else if (word_backlog.size() > 0) begin
          word_on_bus = word_backlog.pop_front();
          word_if.feed_class    <= word_on_bus.kind;
          word_if.data_byte     <= word_on_bus.data;
          word_if.has_byte      <= word_on_bus.has;
          word_if.last          <= word_on_bus.last;
          word_if.event_time    <= word_on_bus.ev;
          word_if.source_time   <= word_on_bus.src;
          word_if.now_time      <= word_on_bus.now;
          word_if.primary_full  <= word_on_bus.pfull;
          word_if.fallback_full <= word_on_bus.ffull;
          word_if.valid <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          word_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each record against the oldest one owed, and stall at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      record_if.ready <= 1'b0;
    end else begin
      if (record_if.valid && record_if.ready) begin
        records_seen++;
        if (due_records.size() == 0) begin
          report_mismatch("record with none owed", 64'(record_if.status), 64'd0);
        end else begin
          head_record = due_records.pop_front();
          if (record_if.status !== head_record.status)
            report_mismatch("status", 64'(record_if.status), 64'(head_record.status));
          if (record_if.outcome !== head_record.outcome)
            report_mismatch("outcome", 64'(record_if.outcome), 64'(head_record.outcome));
          if (record_if.out_feed_class !== head_record.kind)
            report_mismatch("feed class", 64'(record_if.out_feed_class),
                            64'(head_record.kind));
          if (record_if.eff_event_time !== head_record.ev)
            report_mismatch("event time", record_if.eff_event_time, head_record.ev);
          if (record_if.eff_source_time !== head_record.src)
            report_mismatch("source time", record_if.eff_source_time, head_record.src);
          if (record_if.ingest_time !== head_record.now)
            report_mismatch("ingest time", record_if.ingest_time, head_record.now);
          if (record_if.payload_size !== head_record.size)
            report_mismatch("payload size", 64'(record_if.payload_size),
                            64'(head_record.size));
          if (record_if.payload_crc !== head_record.crc)
            report_mismatch("payload crc", 64'(record_if.payload_crc),
                            64'(head_record.crc));
          if (record_if.fallback_uses !== head_record.uses)
            report_mismatch("fallback uses", 64'(record_if.fallback_uses),
                            64'(head_record.uses));
        end
        // Two long hold-offs let the block fill up and stall its input.
        if (records_seen == 40 || records_seen == 75) hold_left = 400;
      end
      if ($urandom_range(0, 149) == 0) recv_calm = !recv_calm;
      if (hold_left > 0) begin
        hold_left--;
        record_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        record_if.ready <= 1'b0;
      end else begin
        record_if.ready <= 1'b1;
        recv_gap = pick_gap(recv_calm);
      end
    end
  end

  function automatic logic signed [63:0] pos_time();
    logic signed [63:0] v;
    v = {$urandom, $urandom};
    v[63] = 1'b0;
    if ($urandom_range(0, 7) == 0) v = 64'($urandom_range(1, 8));
    if (v == 0) v = 1;
    return v;
  endfunction

  function automatic logic signed [63:0] missing_time();
    logic signed [63:0] v;
    case ($urandom_range(0, 2))
      0: begin
        v = 0;
      end
      1: begin
        v = MinTime;
      end
      default: begin
        v = {$urandom, $urandom};
        v[63] = 1'b1;
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [63:0] extreme_time();
    case ($urandom_range(0, 4))
      0: return MinTime;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return MaxTime;
    endcase
  endfunction

  function automatic frame_word_t make_header(input logic [7:0] kind,
                                              input logic signed [63:0] ev,
                                              input logic signed [63:0] src,
                                              input logic signed [63:0] now,
                                              input bit pfull, input bit ffull);
    frame_word_t w;
    w.kind = kind;
    w.data = 8'($urandom_range(0, 255));
    w.has = 1'b0;
    w.last = 1'b1;
    w.ev = ev;
    w.src = src;
    w.now = now;
    w.pfull = pfull;
    w.ffull = ffull;
    return w;
  endfunction

  // Three positive times sorted so that the frame passes the order check.
  function automatic frame_word_t stamp_ordered(input frame_word_t w);
    logic signed [63:0] t;
    w.ev = pos_time();
    w.src = pos_time();
    w.now = pos_time();
    if (w.ev > w.src) begin
      t = w.ev; w.ev = w.src; w.src = t;
    end
    if (w.src > w.now) begin
      t = w.src; w.src = w.now; w.now = t;
    end
    if (w.ev > w.src) begin
      t = w.ev; w.ev = w.src; w.src = t;
    end
    return w;
  endfunction

  function automatic frame_word_t good_header();
    return stamp_ordered(make_header(8'($urandom_range(0, 255)), 0, 0, 0, 1'b0,
                                     1'($urandom_range(0, 1))));
  endfunction

  // Mostly well-ordered headers, with missing, scrambled and extreme times mixed in.
  function automatic frame_word_t random_header();
    frame_word_t w;
    int unsigned pick;
    w = stamp_ordered(make_header(8'($urandom_range(0, 255)), 0, 0, 0,
                                  $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1))));
    pick = $urandom_range(0, 99);
    if (pick >= 55 && pick < 65) begin
      w.src = missing_time();
    end else if (pick >= 65 && pick < 75) begin
      w.ev = missing_time();
    end else if (pick >= 75 && pick < 82) begin
      w.src = missing_time();
      w.ev = missing_time();
    end else if (pick >= 82 && pick < 92) begin
      w.ev = {$urandom, $urandom};
      w.src = {$urandom, $urandom};
      w.now = {$urandom, $urandom};
    end else if (pick >= 92) begin
      w.ev = extreme_time();
      w.src = extreme_time();
      w.now = extreme_time();
    end
    return w;
  endfunction

  // Queue one frame: optional leading blank words, the payload, and the last word.
  task automatic queue_frame(input int unsigned nbytes, input bit tail_byte,
                             input int unsigned lead_blanks, input frame_word_t head);
    frame_word_t w;
    int unsigned body;
    body = (tail_byte && nbytes > 0) ? nbytes - 1 : nbytes;
    for (int unsigned i = 0; i < lead_blanks + body; i++) begin
      w = random_header();
      w.last = 1'b0;
      w.has = (i >= lead_blanks);
      word_backlog.push_back(w);
      if (w.has) words_queued++;
      if (blank_pct > 0 && $urandom_range(0, 99) < blank_pct) begin
        w.has = 1'b0;
        word_backlog.push_back(w);
      end
    end
    head.last = 1'b1;
    head.has = tail_byte && nbytes > 0;
    word_backlog.push_back(head);
    words_queued++;
  endtask

  task automatic queue_random_frame();
    int unsigned pick;
    int unsigned nbytes;
    pick = $urandom_range(0, 99);
    if (pick < 8) nbytes = 0;
    else if (pick < 75) nbytes = $urandom_range(1, 8);
    else if (pick < 95) nbytes = $urandom_range(9, 64);
    else nbytes = $urandom_range(65, 300);
    queue_frame(nbytes, 1'($urandom_range(0, 1)),
                ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0, random_header());
  endtask

  // Hold off until every word is sent and every record is back, plus pipeline slack.
  task automatic drain_records();
    do @(negedge clk_i);
    while (word_backlog.size() != 0 || word_if.valid || due_records.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_truncate(input logic v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    trunc_mode = v;
  endtask

  // Stimulus: directed frames, long frames under both settings, then random traffic.
  initial begin
    frame_word_t head;
    int unsigned target;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    word_if.valid = 1'b0;
    word_if.feed_class = '0;
    word_if.data_byte = '0;
    word_if.has_byte = 1'b0;
    word_if.last = 1'b0;
    word_if.event_time = '0;
    word_if.source_time = '0;
    word_if.now_time = '0;
    word_if.primary_full = 1'b0;
    word_if.fallback_full = 1'b0;
    record_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty frames, including one with both rings full and one after blank words.
    queue_frame(0, 0, 0, make_header(8'h00, 10, 20, 30, 1'b0, 1'b0));
    queue_frame(0, 0, 0, make_header(8'hFF, 10, 20, 30, 1'b1, 1'b1));
    queue_frame(0, 0, 2, make_header(8'h5A, -5, 0, 7, 1'b0, 1'b0));
    // Single-byte frames at the extremes of the byte and of the times.
    head = make_header(8'h00, 1, 1, 1, 1'b0, 1'b0);
    head.data = 8'h00;
    queue_frame(1, 1, 0, head);
    head = make_header(8'hFF, MaxTime, MaxTime, MaxTime, 1'b0, 1'b0);
    head.data = 8'hFF;
    queue_frame(1, 1, 0, head);
    // Timestamp substitution cases.
    queue_frame(3, 0, 0, make_header(8'h11, 100, 0, 200, 1'b0, 1'b0));
    queue_frame(2, 1, 0, make_header(8'h22, MinTime, 150, 150, 1'b0, 1'b0));
    queue_frame(4, 0, 1, make_header(8'h33, 0, -1, 99, 1'b0, 1'b0));
    queue_frame(1, 0, 0, make_header(8'h44, 0, 0, 0, 1'b0, 1'b0));
    queue_frame(2, 1, 0, make_header(8'h55, -1, MinTime, MinTime, 1'b0, 1'b0));
    // Time order rejects.
    queue_frame(1, 1, 0, make_header(8'h66, 30, 20, 40, 1'b0, 1'b0));
    queue_frame(1, 1, 0, make_header(8'h77, 10, 50, 40, 1'b0, 1'b0));
    // Ring full cases, and a time reject that takes precedence over them.
    queue_frame(2, 0, 0, make_header(8'h88, 10, 20, 30, 1'b1, 1'b0));
    queue_frame(2, 1, 0, make_header(8'h99, 10, 20, 30, 1'b1, 1'b1));
    queue_frame(1, 1, 0, make_header(8'hAA, 30, 20, 40, 1'b1, 1'b1));
    drain_records();

    // Oversize frames are dropped; a bad time order is reported before the size.
    set_truncate(1'b0);
    queue_frame(MaxBytes, 1, 0, good_header());
    queue_frame(MaxBytes + 1, 0, 0, good_header());
    queue_frame(MaxBytes + 1, 1, 0, make_header(8'hC3, 9, 3, 12, 1'b0, 1'b0));
    queue_frame(5000, 1, 0, good_header());
    queue_frame(1, 1, 0, good_header());
    drain_records();

    // Oversize frames are clipped, including one past the count saturation.
    set_truncate(1'b1);
    queue_frame(MaxBytes, 0, 0, good_header());
    queue_frame(MaxBytes + 1, 1, 0, good_header());
    queue_frame(5000, 0, 0, good_header());
    head = good_header();
    head.pfull = 1'b1;
    queue_frame(MaxBytes + 4, 1, 0, head);
    queue_frame(1, 1, 0, good_header());
    drain_records();

    // Random traffic under both settings, with blank words mixed in.
    blank_pct = 10;
    target = words_queued + 700;
    while (words_queued < target) queue_random_frame();
    drain_records();
    set_truncate(1'b0);
    target = words_queued + 750;
    while (words_queued < target) queue_random_frame();
    drain_records();

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[frame_ingest_checker.f]
hw/rtl/fic_pkg.sv
hw/rtl/fic_if.sv
hw/rtl/fic_frame_acc.sv
hw/rtl/fic_verdict.sv
hw/rtl/fic_event_cnt.sv
hw/rtl/frame_ingest_checker.sv
hw/rtl/fic_checker.sv
tb/sv/testbench.sv
